### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that carries concurrent checks.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### hw/rtl/iyfp_pkg.sv
// Shared types and constants of the IMU yaw frame parser.
// Depends on nothing; used by the frame receiver, the yaw tracker, the top level and the testbench.
`timescale 1ns / 1ps

package iyfp_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 11;
    localparam logic [3:0]  POS_TYPE    = 4'd1;
    localparam logic [3:0]  POS_YAW_LO  = 4'd6;
    localparam logic [3:0]  POS_YAW_HI  = 4'd7;
    localparam logic [3:0]  POS_LAST    = 4'(FRAME_BYTES - 1);
    localparam logic [7:0]  START_BYTE  = 8'h55;
    localparam logic [7:0]  ANGLE_TYPE  = 8'h53;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration register indexes and reset values
    localparam logic CFG_VALID_MS = 1'b0;
    localparam logic CFG_INVERT   = 1'b1;
    localparam logic [15:0] VALID_MS_RST = 16'd100;

    // Yaw age saturates here
    localparam logic [16:0] AGE_MAX = 17'h1FFFF;

    // Heading wrap limits in tenths of a degree
    localparam logic signed [13:0] HALF_TURN = 14'sd1800;
    localparam logic signed [13:0] FULL_TURN = 14'sd3600;

    // Event from the frame receiver to the yaw tracker
    typedef struct packed {
        logic              accepted;
        logic signed [11:0] yaw;
    } t_frame_evt;

    // One result transaction
    typedef struct packed {
        logic signed [11:0] yaw_tenths;
        logic               yaw_valid;
        logic signed [11:0] heading_error;
        logic               frame_accepted;
    } t_result;

endpackage

### hw/rtl/iyfp_in_if.sv
// Input channel of the IMU yaw frame parser: valid/ready plus item payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface iyfp_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         rx_byte;
    logic signed [11:0] target_heading;

    modport source(output valid, output kind, output rx_byte, output target_heading,
                   input ready);
    modport sink(input valid, input kind, input rx_byte, input target_heading,
                 output ready);
endinterface

### hw/rtl/iyfp_out_if.sv
// Result channel of the IMU yaw frame parser: valid/ready plus result payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface iyfp_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] yaw_tenths;
    logic               yaw_valid;
    logic signed [11:0] heading_error;
    logic               frame_accepted;

    modport source(output valid, output yaw_tenths, output yaw_valid,
                   output heading_error, output frame_accepted, input ready);
    modport sink(input valid, input yaw_tenths, input yaw_valid,
                 input heading_error, input frame_accepted, output ready);
endinterface

### hw/rtl/iyfp_frame_rx.sv
// Byte framing, checksum and type check, and yaw word decode.
// Depends on iyfp_pkg.
`timescale 1ns / 1ps

module iyfp_frame_rx (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_invert,
    output iyfp_pkg::t_frame_evt o_evt
);

    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_raw, n_raw;
    logic signed [11:0] n_dec_yaw;
    logic        n_accepted;

    logic signed [24:0] w_prod;
    logic signed [24:0] w_bias;
    logic signed [12:0] w_quot;

    // Decode raw word: raw * 1800 / 32768 == raw * 225 / 4096, toward zero
    always_comb begin
        w_prod = ($signed({{9{r_raw[15]}}, r_raw}) <<< 8)
               - ($signed({{9{r_raw[15]}}, r_raw}) <<< 5)
               + $signed({{9{r_raw[15]}}, r_raw});
        w_bias = w_prod[24] ? (w_prod + 25'sd4095) : w_prod;
        w_quot = 13'(w_bias >>> 12);
        n_dec_yaw = i_invert ? 12'(-w_quot) : 12'(w_quot);
    end

    // Advance the frame position and gather the fields
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_type     = r_type;
        n_raw      = r_raw;
        n_accepted = 1'b0;
        if (r_pos == 4'd0) begin
            if (i_byte == iyfp_pkg::START_BYTE) begin
                n_sum = i_byte;
                n_pos = 4'd1;
            end
        end else if (r_pos >= iyfp_pkg::POS_LAST) begin
            n_accepted = (r_sum == i_byte) && (r_type == iyfp_pkg::ANGLE_TYPE);
            n_pos      = 4'd0;
        end else begin
            if (r_pos == iyfp_pkg::POS_TYPE) begin
                n_type = i_byte;
            end else if (r_pos == iyfp_pkg::POS_YAW_LO) begin
                n_raw[7:0] = i_byte;
            end else if (r_pos == iyfp_pkg::POS_YAW_HI) begin
                n_raw[15:8] = i_byte;
            end
            n_sum = r_sum + i_byte;
            n_pos = r_pos + 4'd1;
        end
    end

    // Hold framing state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_type <= '0;
            r_raw  <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_type <= n_type;
            r_raw  <= n_raw;
        end
    end

    assign o_evt.accepted = i_step && n_accepted;
    assign o_evt.yaw      = n_dec_yaw;

endmodule

### hw/rtl/iyfp_yaw_track.sv
// Stored yaw, its age and freshness, and the wrapped heading error.
// Depends on iyfp_pkg.
`timescale 1ns / 1ps

module iyfp_yaw_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_tick,
    input  iyfp_pkg::t_frame_evt i_evt,
    input  logic [15:0]          i_valid_ms,
    input  logic signed [11:0]   i_target,
    output iyfp_pkg::t_result    o_result
);

    logic signed [11:0] r_yaw, n_yaw;
    logic               r_rcvd, n_rcvd;
    logic [16:0]        r_age, n_age;
    logic signed [13:0] w_diff;
    logic signed [13:0] w_err;

    // Age the yaw on ticks, refresh it on an accepted frame
    always_comb begin
        n_yaw  = r_yaw;
        n_rcvd = r_rcvd;
        n_age  = r_age;
        if (i_tick && (r_age < iyfp_pkg::AGE_MAX)) begin
            n_age = r_age + 17'd1;
        end
        if (i_evt.accepted) begin
            n_yaw  = i_evt.yaw;
            n_rcvd = 1'b1;
            n_age  = '0;
        end
    end

    // Wrap target minus yaw by one turn
    always_comb begin
        w_diff = 14'(i_target) - 14'(n_yaw);
        if (w_diff > iyfp_pkg::HALF_TURN) begin
            w_err = w_diff - iyfp_pkg::FULL_TURN;
        end else if (w_diff < -iyfp_pkg::HALF_TURN) begin
            w_err = w_diff + iyfp_pkg::FULL_TURN;
        end else begin
            w_err = w_diff;
        end
    end

    assign o_result.yaw_tenths     = n_yaw;
    assign o_result.yaw_valid      = n_rcvd && (n_age <= {1'b0, i_valid_ms});
    assign o_result.heading_error  = 12'(w_err);
    assign o_result.frame_accepted = i_evt.accepted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw  <= '0;
            r_rcvd <= 1'b0;
            r_age  <= '0;
        end else if (i_step) begin
            r_yaw  <= n_yaw;
            r_rcvd <= n_rcvd;
            r_age  <= n_age;
        end
    end

endmodule

### hw/rtl/imu_yaw_frame_parser.sv
// Top level of the IMU yaw frame parser: input register, result register, config.
// Depends on iyfp_pkg, iyfp_in_if, iyfp_out_if, iyfp_frame_rx, iyfp_yaw_track.
//
//   channel  | direction | carries
//   ---------+-----------+----------------------------------------------------
//   i_in     | in        | kind, rx_byte, target_heading
//   o_out    | out       | yaw_tenths, yaw_valid, heading_error, frame_accepted
//   i_cfg_*  | in        | write enable, register index, 16-bit data
//
// Every item yields one result: the item is captured in the input register, and
// its result in the result register, which offers it on o_out. One item per cycle
// is sustained while results are taken. The input register feeds one pass of
// framing and yaw logic that fills the result register. Both stages hold while
// the result is not taken, and i_in.ready then follows o_out.ready. Synchronous
// active-low reset empties both stages and restores the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imu_yaw_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iyfp_in_if.sink     i_in,
    iyfp_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic               r_in_vld;
    logic               r_kind;
    logic [7:0]         r_byte;
    logic signed [11:0] r_target;
    logic               r_out_vld;
    iyfp_pkg::t_result  r_out;
    logic [15:0]        r_valid_ms;
    logic               r_invert;

    logic                 w_adv;
    logic                 w_commit;
    iyfp_pkg::t_frame_evt w_evt;
    iyfp_pkg::t_result    w_result;

    // Pipeline control
    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_commit   = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_ms <= iyfp_pkg::VALID_MS_RST;
            r_invert   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iyfp_pkg::CFG_VALID_MS: r_valid_ms <= i_cfg_data;
                iyfp_pkg::CFG_INVERT:   r_invert   <= i_cfg_data[0];
                default:                r_invert   <= r_invert;
            endcase
        end
    end

    // Input register: capture a transaction when the stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind   <= i_in.kind;
            r_byte   <= i_in.rx_byte;
            r_target <= i_in.target_heading;
        end
    end

    iyfp_frame_rx u_frame_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_commit && (r_kind == iyfp_pkg::KIND_BYTE)),
        .i_byte   (r_byte),
        .i_invert (r_invert),
        .o_evt    (w_evt)
    );

    iyfp_yaw_track u_yaw_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_commit),
        .i_tick     (r_kind == iyfp_pkg::KIND_TICK),
        .i_evt      (w_evt),
        .i_valid_ms (r_valid_ms),
        .i_target   (r_target),
        .o_result   (w_result)
    );

    // Result register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.yaw_tenths     = r_out.yaw_tenths;
    assign o_out.yaw_valid      = r_out.yaw_valid;
    assign o_out.heading_error  = r_out.heading_error;
    assign o_out.frame_accepted = r_out.frame_accepted;

    // A freshly accepted frame is always reported as valid
    `ASSERT_CLK(a_accept_valid, i_clk, i_rst_n, (o_out.valid && o_out.frame_accepted) |-> o_out.yaw_valid)
    // Wrapped error stays within half a turn
    `ASSERT_NEVER(a_err_range, i_clk, i_rst_n, o_out.valid && ((o_out.heading_error > 12'sd1800) || (o_out.heading_error < -12'sd1800)))
    // Stored yaw stays within half a turn
    `ASSERT_NEVER(a_yaw_range, i_clk, i_rst_n, o_out.valid && ((o_out.yaw_tenths > 12'sd1800) || (o_out.yaw_tenths < -12'sd1800)))

endmodule

### tb/iyfp_yaw_checker.sv
// Yaw report checker for the IMU yaw frame parser: predicts every result from the
// input and configuration traffic and compares it with the result channel.
// Depends on iyfp_pkg, iyfp_in_if and iyfp_out_if.
`timescale 1ns / 1ps

module iyfp_yaw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iyfp_in_if          i_in_mon,
    iyfp_out_if         i_out_mon,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_mismatches,
    output int          o_checked,
    output int          o_frames_ok
);

    // Raw angle word to tenths of a degree
    localparam int YAW_SCALE_NUM = 1800;
    localparam int YAW_SCALE_DEN = 32768;
    localparam int REPORT_LIMIT  = 10;

    // Parser copy: configuration
    logic [15:0]        valid_ms;
    logic               heading_invert;

    // Parser copy: frame and yaw state
    logic [3:0]         frame_pos;
    logic [7:0]         frame_sum;
    logic [7:0]         frame_type;
    logic [15:0]        raw_yaw;
    logic signed [11:0] yaw_now;
    logic               yaw_seen;
    logic [16:0]        yaw_age;

    iyfp_pkg::t_result yaw_reports_q[$];

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        o_checked    = 0;
        o_frames_ok  = 0;
    end

    // Advance the parser copy by one item and return the report it causes
    function automatic iyfp_pkg::t_result parse_item(logic kind, logic [7:0] rx,
                                                     logic signed [11:0] target);
        iyfp_pkg::t_result rpt;
        logic    took_frame;
        int      raw;
        int      yaw;
        int      err;
        took_frame = 1'b0;
        if (kind == iyfp_pkg::KIND_TICK) begin
            if (yaw_age != iyfp_pkg::AGE_MAX) begin
                yaw_age = yaw_age + 17'd1;
            end
        end else if (frame_pos == 4'd0) begin
            // Drop anything but a start byte while hunting
            if (rx == iyfp_pkg::START_BYTE) begin
                frame_sum = rx;
                frame_pos = 4'd1;
            end
        end else if (frame_pos >= iyfp_pkg::POS_LAST) begin
            if (frame_sum == rx && frame_type == iyfp_pkg::ANGLE_TYPE) begin
                raw = $signed(raw_yaw);
                yaw = (raw * YAW_SCALE_NUM) / YAW_SCALE_DEN;
                if (heading_invert) begin
                    yaw = -yaw;
                end
                yaw_now    = 12'(yaw);
                yaw_seen   = 1'b1;
                yaw_age    = '0;
                took_frame = 1'b1;
            end
            frame_pos = 4'd0;
        end else begin
            case (frame_pos)
                iyfp_pkg::POS_TYPE:   frame_type    = rx;
                iyfp_pkg::POS_YAW_LO: raw_yaw[7:0]  = rx;
                iyfp_pkg::POS_YAW_HI: raw_yaw[15:8] = rx;
                default: ;
            endcase
            frame_sum = frame_sum + rx;
            frame_pos = frame_pos + 4'd1;
        end

        // Wrap target minus yaw by one turn at most
        err = int'(target) - int'(yaw_now);
        if (err > int'(iyfp_pkg::HALF_TURN)) begin
            err = err - int'(iyfp_pkg::FULL_TURN);
        end else if (err < -int'(iyfp_pkg::HALF_TURN)) begin
            err = err + int'(iyfp_pkg::FULL_TURN);
        end

        rpt.yaw_tenths     = yaw_now;
        rpt.yaw_valid      = yaw_seen && (yaw_age <= {1'b0, valid_ms});
        rpt.heading_error  = 12'(err);
        rpt.frame_accepted = took_frame;
        return rpt;
    endfunction

    always @(posedge i_clk) begin
        iyfp_pkg::t_result want;
        iyfp_pkg::t_result got;
        if (!i_rst_n) begin
            valid_ms       = iyfp_pkg::VALID_MS_RST;
            heading_invert = 1'b0;
            frame_pos      = '0;
            frame_sum      = '0;
            frame_type     = '0;
            raw_yaw        = '0;
            yaw_now        = '0;
            yaw_seen       = 1'b0;
            yaw_age        = '0;
            yaw_reports_q.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == iyfp_pkg::CFG_VALID_MS) begin
                    valid_ms = i_cfg_data;
                end else if (i_cfg_idx == iyfp_pkg::CFG_INVERT) begin
                    heading_invert = i_cfg_data[0];
                end
            end

            // Predict on every input transaction
            if (i_in_mon.valid && i_in_mon.ready) begin
                want = parse_item(i_in_mon.kind, i_in_mon.rx_byte, i_in_mon.target_heading);
                if (want.frame_accepted) begin
                    o_frames_ok = o_frames_ok + 1;
                end
                yaw_reports_q.push_back(want);
            end

            // Compare every result transaction with the oldest prediction
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.yaw_tenths     = i_out_mon.yaw_tenths;
                got.yaw_valid      = i_out_mon.yaw_valid;
                got.heading_error  = i_out_mon.heading_error;
                got.frame_accepted = i_out_mon.frame_accepted;
                if (yaw_reports_q.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    if (o_mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result yaw=%0d valid=%0b err=%0d acc=%0b",
                                 $time, got.yaw_tenths, got.yaw_valid,
                                 got.heading_error, got.frame_accepted);
                    end
                end else begin
                    want = yaw_reports_q.pop_front();
                    o_checked = o_checked + 1;
                    if (got.yaw_tenths !== want.yaw_tenths
                            || got.yaw_valid !== want.yaw_valid
                            || got.heading_error !== want.heading_error
                            || got.frame_accepted !== want.frame_accepted) begin
                        o_mismatches = o_mismatches + 1;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch exp yaw=%0d valid=%0b err=%0d acc=%0b",
                                     $time, want.yaw_tenths, want.yaw_valid,
                                     want.heading_error, want.frame_accepted);
                            $display("%0t:                 got yaw=%0d valid=%0b err=%0d acc=%0b",
                                     $time, got.yaw_tenths, got.yaw_valid,
                                     got.heading_error, got.frame_accepted);
                        end
                    end
                end
            end
        end
        o_pending = yaw_reports_q.size();
    end

endmodule

### tb/tb_imu_yaw_frame_parser.sv
// Testbench top for the IMU yaw frame parser: clock, reset, register writes,
// byte and tick stimulus with random gaps and stalls, and the final verdict.
// Depends on iyfp_pkg, the two channel interfaces, the block and iyfp_yaw_checker.
`timescale 1ns / 1ps

module tb_imu_yaw_frame_parser;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MIX_ITEMS       = 170;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;

    int pending;
    int mismatches;
    int checked;
    int frames_ok;

    int gap_pct;
    int stall_pct;
    bit hold_req;
    int hold_left;

    int n_items;
    int n_ticks;
    int n_bytes;
    int n_settings;

    iyfp_in_if  in_ch();
    iyfp_out_if out_ch();

    imu_yaw_frame_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    iyfp_yaw_checker yaw_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_frames_ok  (frames_ok)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Give up on a hung run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result receiver: random stalls plus a long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left    = hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic signed [11:0] rand_target();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) return 12'sh800;
        if (pick < 6) return 12'sh7FF;
        if (pick < 8) return iyfp_pkg::HALF_TURN[11:0];
        if (pick < 10) return 12'(-int'(iyfp_pkg::HALF_TURN));
        if (pick < 16) return 12'($urandom);
        return 12'(int'($urandom_range(0, 3600)) - int'(iyfp_pkg::HALF_TURN));
    endfunction

    function automatic logic [15:0] rand_raw_yaw();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) return 16'h8000;
        if (pick < 10) return 16'h7FFF;
        if (pick < 13) return 16'h0000;
        if (pick < 16) return 16'hFFFF;
        // Small negatives truncate toward zero
        if (pick < 24) return 16'(-int'($urandom_range(1, 40)));
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] wrong_type();
        logic [7:0] t;
        t = 8'($urandom);
        while (t == iyfp_pkg::ANGLE_TYPE) begin
            t = 8'($urandom);
        end
        return t;
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic send_item(input logic kind, input logic [7:0] rx,
                             input logic signed [11:0] target);
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= kind;
        in_ch.rx_byte        <= rx;
        in_ch.target_heading <= target;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        n_items = n_items + 1;
        if (kind == iyfp_pkg::KIND_TICK) begin
            n_ticks = n_ticks + 1;
        end else begin
            n_bytes = n_bytes + 1;
        end
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(iyfp_pkg::KIND_BYTE, rx, rand_target());
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(iyfp_pkg::KIND_TICK, 8'($urandom), rand_target());
    endtask

    // Send one frame, with ticks mixed in between its bytes
    task automatic send_frame(input logic [15:0] raw, input logic [7:0] ftype,
                              input bit bad_sum, input int tick_pct);
        logic [7:0] fb [iyfp_pkg::FRAME_BYTES];
        logic [7:0] sum;
        fb[0] = iyfp_pkg::START_BYTE;
        fb[iyfp_pkg::POS_TYPE] = ftype;
        for (int i = 2; i < iyfp_pkg::FRAME_BYTES; i++) begin
            fb[i] = 8'($urandom);
        end
        fb[iyfp_pkg::POS_YAW_LO] = raw[7:0];
        fb[iyfp_pkg::POS_YAW_HI] = raw[15:8];
        sum = '0;
        for (int i = 0; i < int'(iyfp_pkg::POS_LAST); i++) begin
            sum = sum + fb[i];
        end
        fb[iyfp_pkg::POS_LAST] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < iyfp_pkg::FRAME_BYTES; i++) begin
            if ($urandom_range(99) < tick_pct) begin
                send_ticks(1);
            end
            send_byte(fb[i]);
        end
    endtask

    // Lower valid and hold until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] vms, input logic invert);
        cfg_write(iyfp_pkg::CFG_VALID_MS, vms);
        cfg_write(iyfp_pkg::CFG_INVERT, {15'd0, invert});
        n_settings = n_settings + 1;
    endtask

    // Mostly well-formed frames, plus broken frames, noise and tick bursts
    task automatic run_mix(input int count, input int burst_max);
        int stop_at;
        int pick;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                send_frame(rand_raw_yaw(), iyfp_pkg::ANGLE_TYPE, 1'b0, 8);
            end else if (pick < 72) begin
                send_frame(rand_raw_yaw(), iyfp_pkg::ANGLE_TYPE, 1'b1, 8);
            end else if (pick < 80) begin
                send_frame(rand_raw_yaw(), wrong_type(), 1'b0, 8);
            end else if (pick < 87) begin
                send_byte(iyfp_pkg::START_BYTE);
                repeat ($urandom_range(1, 9)) send_byte(8'($urandom));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                send_ticks($urandom_range(1, burst_max));
            end
            if ($urandom_range(99) < 40) begin
                send_ticks($urandom_range(0, burst_max));
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = iyfp_pkg::CFG_VALID_MS;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = iyfp_pkg::KIND_BYTE;
        in_ch.rx_byte        = '0;
        in_ch.target_heading = '0;
        gap_pct              = 8;
        stall_pct            = 8;
        hold_req             = 1'b0;
        n_items              = 0;
        n_ticks              = 0;
        n_bytes              = 0;
        n_settings           = 1;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: tick before any yaw, stray bytes, extreme yaw, wrong type
        send_item(iyfp_pkg::KIND_TICK, 8'hFF, 12'sh800);
        send_item(iyfp_pkg::KIND_BYTE, 8'h00, 12'sh7FF);
        send_item(iyfp_pkg::KIND_BYTE, 8'hFF, 12'(-int'(iyfp_pkg::HALF_TURN)));
        send_frame(16'h8000, iyfp_pkg::ANGLE_TYPE, 1'b0, 0);
        send_frame(16'h7FFF, 8'h51, 1'b0, 0);
        drain();

        // Zero age limit, inverted heading
        set_config(16'd0, 1'b1);
        run_mix(MIX_ITEMS, 3);
        drain();

        // Widest age limit, no idling, receiver holds off while items keep coming
        set_config(16'hFFFF, 1'b0);
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        run_mix(MIX_ITEMS, 20);
        drain();

        // Short random age limit so validity toggles
        gap_pct   = 8;
        stall_pct = 8;
        set_config(16'($urandom_range(5, 40)), 1'b1);
        run_mix(MIX_ITEMS, 60);
        drain();

        // Back to reset values with long tick bursts
        set_config(iyfp_pkg::VALID_MS_RST, 1'b0);
        run_mix(MIX_ITEMS, 120);
        drain();

        // Tight age limit
        set_config(16'd3, 1'b0);
        run_mix(MIX_ITEMS, 8);
        drain();

        // Let any stray result show up before the verdict
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items (%0d bytes, %0d ticks) over %0d register settings.",
                 n_items, n_bytes, n_ticks, n_settings);
        $display("Checked %0d results, %0d frames accepted, %0d mismatches.",
                 checked, frames_ok, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
